// ===== sv/dpp_pkg.sv =====
// Shared types and constants of the DHCP/BOOTP packet parser.
// Used by the front parser, the transaction queue and the result expander.
package dpp_pkg;

  localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
  localparam logic [7:0]  OPT_END      = 8'd255;
  localparam logic [7:0]  OPT_PAD      = 8'd0;
  localparam logic [7:0]  HTYPE_ETHER  = 8'd1;
  localparam logic [7:0]  HLEN_ETHER   = 8'd6;
  localparam logic [7:0]  OP_REPLY     = 8'd2;
  localparam logic [7:0]  OP_REQUEST   = 8'd1;
  localparam logic [7:0]  OPT_MSG_TYPE = 8'd53;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_OPTION = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_OP    = 3'd2;
  localparam logic [2:0] ST_BAD_HTYPE = 3'd3;
  localparam logic [2:0] ST_BAD_HLEN  = 3'd4;
  localparam logic [2:0] ST_NO_TYPE   = 3'd5;

  localparam logic [3:0] HF_OP     = 4'd0;
  localparam logic [3:0] HF_XID    = 4'd1;
  localparam logic [3:0] HF_SECS   = 4'd2;
  localparam logic [3:0] HF_FLAGS  = 4'd3;
  localparam logic [3:0] HF_CIADDR = 4'd4;
  localparam logic [3:0] HF_YIADDR = 4'd5;
  localparam logic [3:0] HF_SIADDR = 4'd6;
  localparam logic [3:0] HF_GIADDR = 4'd7;
  localparam logic [3:0] HF_CHADDR = 4'd8;
  localparam logic [3:0] HF_COUNT  = 4'd9;

  typedef struct packed {
    logic [7:0]       op;
    logic [31:0]      xid;
    logic [15:0]      secs;
    logic [15:0]      flags;
    logic [3:0][31:0] ip;
    logic [47:0]      chaddr;
  } hdr_t;

  typedef struct packed {
    logic       hdr_en;
    logic       opt_en;
    logic       end_en;
    hdr_t       hdr;
    logic [7:0] code;
    logic [7:0] idx;
    logic [7:0] data;
    logic [2:0] status;
    logic [7:0] end_value;
  } qent_t;

endpackage

// ===== sv/dpp_stream_if.sv =====
// Handshake channels of the packet parser: raw bytes in, results out.
// Depends on nothing.
interface dpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dpp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tag;
  logic [7:0]  byte_index;
  logic [47:0] value;
  logic [2:0]  status;
  logic        last_result;
  modport source (output valid, kind, tag, byte_index, value, status, last_result,
                  input ready);
  modport sink   (input valid, kind, tag, byte_index, value, status, last_result,
                  output ready);
endinterface

// ===== sv/dpp_front.sv =====
// Front parser: accepts packet bytes, tracks header, cookie and option walk.
// Pushes one transaction per byte that causes results. Uses dpp_pkg, dpp_byte_if.
module dpp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  dpp_byte_if.sink       in_i,
  input  logic           full_i,
  output logic           push_o,
  output dpp_pkg::qent_t ent_o
);
  import dpp_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_COOKIE = 3'd1;
  localparam logic [2:0] PH_CODE   = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_IDLE   = 3'd5;

  localparam logic [7:0] POS_HDR_LAST    = 8'd235;
  localparam logic [7:0] POS_COOKIE_LAST = 8'd239;
  localparam logic [7:0] POS_SAT         = 8'd240;

  logic [7:0]  pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [2:0]  err_q, err_d;
  hdr_t        hdr_q, hdr_d;
  logic [31:0] cookie_q, cookie_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  pidx_q, pidx_d;
  logic        seen_q, seen_d;
  logic [7:0]  mtype_q, mtype_d;
  logic [7:0]  ipoff;
  logic [7:0]  b;
  logic        accept;
  qent_t       ent;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & ~full_i;
  assign b          = in_i.data_byte;
  assign ipoff      = pos_q - 8'd12;

  always_comb begin
    pos_d    = (pos_q < POS_SAT) ? pos_q + 8'd1 : pos_q;
    phase_d  = phase_q;
    err_d    = err_q;
    hdr_d    = hdr_q;
    cookie_d = cookie_q;
    code_d   = code_q;
    rem_d    = rem_q;
    pidx_d   = pidx_q;
    seen_d   = seen_q;
    mtype_d  = mtype_q;
    ent      = '0;
    ent.hdr  = hdr_q;
    case (phase_q)
      PH_HEADER: begin
        if (pos_q == 8'd0) begin
          hdr_d.op = b;
          if (b != OP_REQUEST && b != OP_REPLY && err_q == ST_OK) begin
            err_d = ST_BAD_OP;
          end
        end else if (pos_q == 8'd1) begin
          if (b != HTYPE_ETHER && err_q == ST_OK) err_d = ST_BAD_HTYPE;
        end else if (pos_q == 8'd2) begin
          if (b != HLEN_ETHER && err_q == ST_OK) err_d = ST_BAD_HLEN;
        end else if (pos_q >= 8'd4 && pos_q <= 8'd7) begin
          hdr_d.xid = {hdr_q.xid[23:0], b};
        end else if (pos_q >= 8'd8 && pos_q <= 8'd9) begin
          hdr_d.secs = {hdr_q.secs[7:0], b};
        end else if (pos_q >= 8'd10 && pos_q <= 8'd11) begin
          hdr_d.flags = {hdr_q.flags[7:0], b};
        end else if (pos_q >= 8'd12 && pos_q <= 8'd27) begin
          hdr_d.ip[ipoff[3:2]] = {hdr_q.ip[ipoff[3:2]][23:0], b};
        end else if (pos_q >= 8'd28 && pos_q <= 8'd33) begin
          hdr_d.chaddr = {hdr_q.chaddr[39:0], b};
        end
        if (pos_q == POS_HDR_LAST) begin
          if (err_q != ST_OK) begin
            phase_d = PH_IDLE;
          end else begin
            ent.hdr_en = 1'b1;
            phase_d    = PH_COOKIE;
          end
        end
      end
      PH_COOKIE: begin
        cookie_d = {cookie_q[23:0], b};
        if (pos_q >= POS_COOKIE_LAST) begin
          phase_d = (cookie_d == MAGIC_COOKIE) ? PH_CODE : PH_IDLE;
        end
      end
      PH_CODE: begin
        if (b == OPT_END) begin
          phase_d = PH_IDLE;
        end else if (b != OPT_PAD) begin
          code_d  = b;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        rem_d   = b;
        pidx_d  = 8'd0;
        phase_d = (b == 8'd0) ? PH_CODE : PH_DATA;
      end
      PH_DATA: begin
        ent.opt_en = 1'b1;
        ent.code   = code_q;
        ent.idx    = pidx_q;
        ent.data   = b;
        if (code_q == OPT_MSG_TYPE && !seen_q && pidx_q == 8'd0) mtype_d = b;
        pidx_d = pidx_q + 8'd1;
        rem_d  = rem_q - 8'd1;
        if (rem_d == 8'd0) begin
          if (code_q == OPT_MSG_TYPE) seen_d = 1'b1;
          phase_d = PH_CODE;
        end
      end
      default: ;
    endcase

    if (in_i.last_byte) begin
      ent.end_en = 1'b1;
      if (pos_q < POS_HDR_LAST) begin
        ent.status = ST_SHORT;
      end else if (err_d != ST_OK) begin
        ent.status = err_d;
      end else if (seen_d) begin
        ent.status    = ST_OK;
        ent.end_value = mtype_d;
      end else begin
        ent.status = ST_NO_TYPE;
      end
      pos_d   = 8'd0;
      phase_d = PH_HEADER;
      err_d   = ST_OK;
      seen_d  = 1'b0;
      mtype_d = 8'd0;
    end
  end

  assign push_o = accept & (ent.hdr_en | ent.opt_en | ent.end_en);
  assign ent_o  = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_HEADER;
      err_q   <= ST_OK;
      seen_q  <= 1'b0;
      mtype_q <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      err_q   <= err_d;
      seen_q  <= seen_d;
      mtype_q <= mtype_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q    <= hdr_d;
      cookie_q <= cookie_d;
      code_q   <= code_d;
      rem_q    <= rem_d;
      pidx_q   <= pidx_d;
    end
  end

endmodule

// ===== sv/dpp_queue.sv =====
// Short transaction queue between the front parser and the result expander.
// Uses dpp_pkg for the entry type.
module dpp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dpp_pkg::qent_t ent_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dpp_pkg::qent_t head_o
);
  import dpp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= ent_i;
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("transaction pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("transaction popped from empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("queue count lost a transaction");

endmodule

// ===== sv/dpp_back.sv =====
// Result expander: turns queued transactions into result items.
// A header transaction yields nine field results. Uses dpp_pkg, dpp_result_if.
module dpp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  dpp_pkg::qent_t head_i,
  output logic           pop_o,
  dpp_result_if.source   out_o
);
  import dpp_pkg::*;

  qent_t       cur_q;
  logic        cur_vld_q;
  logic [3:0]  step_q;
  logic [3:0]  total;
  logic        is_last;
  logic        load_out;
  logic        out_vld_q;
  logic [1:0]  kind_d, kind_q;
  logic [7:0]  tag_d, tag_q;
  logic [7:0]  idx_d, idx_q;
  logic [47:0] val_d, val_q;
  logic [2:0]  st_d, st_q;
  logic        lastr_q;

  assign total    = (cur_q.hdr_en ? HF_COUNT : 4'd0) + {3'd0, cur_q.opt_en}
                    + {3'd0, cur_q.end_en};
  assign is_last  = (step_q == total - 4'd1);
  assign load_out = cur_vld_q & (~out_vld_q | out_o.ready);
  assign pop_o    = ~empty_i & (~cur_vld_q | (load_out & is_last));

  always_comb begin
    kind_d = KIND_STATUS;
    tag_d  = '0;
    idx_d  = '0;
    val_d  = '0;
    st_d   = ST_OK;
    if (cur_q.hdr_en && step_q < HF_COUNT) begin
      kind_d = KIND_HEADER;
      tag_d  = {4'd0, step_q};
      case (step_q)
        HF_OP:     val_d = {40'd0, cur_q.hdr.op};
        HF_XID:    val_d = {16'd0, cur_q.hdr.xid};
        HF_SECS:   val_d = {32'd0, cur_q.hdr.secs};
        HF_FLAGS:  val_d = {32'd0, cur_q.hdr.flags};
        HF_CIADDR: val_d = {16'd0, cur_q.hdr.ip[0]};
        HF_YIADDR: val_d = {16'd0, cur_q.hdr.ip[1]};
        HF_SIADDR: val_d = {16'd0, cur_q.hdr.ip[2]};
        HF_GIADDR: val_d = {16'd0, cur_q.hdr.ip[3]};
        HF_CHADDR: val_d = cur_q.hdr.chaddr;
        default:   val_d = '0;
      endcase
    end else if (cur_q.opt_en && step_q == 4'd0) begin
      kind_d = KIND_OPTION;
      tag_d  = cur_q.code;
      idx_d  = cur_q.idx;
      val_d  = {40'd0, cur_q.data};
    end else begin
      val_d = {40'd0, cur_q.end_value};
      st_d  = cur_q.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_vld_q <= 1'b1;
        step_q    <= '0;
      end else if (load_out && is_last) begin
        cur_vld_q <= 1'b0;
      end else if (load_out) begin
        step_q <= step_q + 4'd1;
      end
      if (load_out)          out_vld_q <= 1'b1;
      else if (out_o.ready)  out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (load_out) begin
      kind_q  <= kind_d;
      tag_q   <= tag_d;
      idx_q   <= idx_d;
      val_q   <= val_d;
      st_q    <= st_d;
      lastr_q <= is_last;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.kind        = kind_q;
  assign out_o.tag         = tag_q;
  assign out_o.byte_index  = idx_q;
  assign out_o.value       = val_q;
  assign out_o.status      = st_q;
  assign out_o.last_result = lastr_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (step_q < total))
    else $error("expander step beyond transaction length");
  a_pop_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cur_vld_q) |-> (load_out && is_last))
    else $error("transaction overwritten before fully expanded");
  a_nonempty_ent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (cur_q.hdr_en || cur_q.opt_en || cur_q.end_en))
    else $error("empty transaction reached the expander");

endmodule

// ===== sv/dhcp_packet_parser_core.sv =====
// DHCP/BOOTP packet parser, top level. One packet byte per transaction in.
// Results pass the queue, the expander's transaction and output registers.
// One byte per cycle while the queue has room; a header-complete byte gives 9 or
// 10 results, one per ready cycle, absorbed by a DEPTH-entry queue.
// Reset: rst_ni asynchronously clears parse state, queue and output valid.
module dhcp_packet_parser_core #(
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dpp_byte_if.sink     in_i,
  dpp_result_if.source out_o
);
  import dpp_pkg::*;

  logic  push, full, pop, empty;
  qent_t ent, head;

  dpp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .ent_o  (ent)
  );

  dpp_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  dpp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for dhcp_packet_parser_core: byte stream in, checked results out.
// Depends on dpp_pkg, dpp_byte_if, dpp_result_if and the parser RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dpp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_COOKIE, PH_CODE, PH_LEN, PH_DATA, PH_IDLE
  } parse_phase_e;

  typedef enum logic [1:0] {
    PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH
  } pace_e;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       hold;
  } pkt_byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [7:0]  idx;
    logic [47:0] value;
    logic [2:0]  status;
    logic        last;
  } parse_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dpp_byte_if   in_if ();
  dpp_result_if out_if ();

  dhcp_packet_parser_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  pkt_byte_t     tx_bytes[$];
  parse_result_t parse_results_due[$];
  logic          hold_next;
  int            total_bytes;
  int            packets_built;
  int            bytes_accepted;
  int            results_checked;
  int            option_results;
  int            status_results;
  int            mismatches;

  // Parser state mirror
  logic [7:0]   pos;
  parse_phase_e phase;
  logic [2:0]   err;
  logic [7:0]   op_q;
  logic [31:0]  xid;
  logic [15:0]  secs;
  logic [15:0]  flags;
  logic [31:0]  ip_addr [4];
  logic [47:0]  chaddr;
  logic [31:0]  cookie;
  logic [7:0]   opt_code;
  logic [7:0]   remaining;
  logic [7:0]   pidx;
  logic         type_seen;
  logic [7:0]   msg_type;

  function automatic void reset_parser();
    pos       = '0;
    phase     = PH_HEADER;
    err       = ST_OK;
    op_q      = '0;
    xid       = '0;
    secs      = '0;
    flags     = '0;
    for (int k = 0; k < 4; k++) ip_addr[k] = '0;
    chaddr    = '0;
    cookie    = '0;
    opt_code  = '0;
    remaining = '0;
    pidx      = '0;
    type_seen = 1'b0;
    msg_type  = '0;
  endfunction

  function automatic void parse_dhcp_byte(input logic [7:0] b, input logic last);
    parse_result_t outs[$];
    logic [47:0]   hdr_vals [9];
    logic [7:0]    at;
    logic [7:0]    rel;
    logic [2:0]    st;
    logic [47:0]   val;
    at = pos;
    case (phase)
      PH_HEADER: begin
        rel = at - 8'd12;
        if (at == 0) begin
          op_q = b;
          if (b != OP_REQUEST && b != OP_REPLY && err == ST_OK) err = ST_BAD_OP;
        end else if (at == 1) begin
          if (b != HTYPE_ETHER && err == ST_OK) err = ST_BAD_HTYPE;
        end else if (at == 2) begin
          if (b != HLEN_ETHER && err == ST_OK) err = ST_BAD_HLEN;
        end else if (at >= 4 && at <= 7) begin
          xid = {xid[23:0], b};
        end else if (at >= 8 && at <= 9) begin
          secs = {secs[7:0], b};
        end else if (at >= 10 && at <= 11) begin
          flags = {flags[7:0], b};
        end else if (at >= 12 && at <= 27) begin
          ip_addr[rel[3:2]] = {ip_addr[rel[3:2]][23:0], b};
        end else if (at >= 28 && at <= 33) begin
          chaddr = {chaddr[39:0], b};
        end
        if (at == 8'd235) begin
          if (err != ST_OK) begin
            phase = PH_IDLE;
          end else begin
            hdr_vals = '{48'(op_q), 48'(xid), 48'(secs), 48'(flags), 48'(ip_addr[0]),
                         48'(ip_addr[1]), 48'(ip_addr[2]), 48'(ip_addr[3]), chaddr};
            for (int f = 0; f < HF_COUNT; f++)
              outs.push_back('{KIND_HEADER, 8'(f), 8'd0, hdr_vals[f], ST_OK, 1'b0});
            phase = PH_COOKIE;
          end
        end
      end
      PH_COOKIE: begin
        cookie = {cookie[23:0], b};
        if (at >= 8'd239) phase = (cookie == MAGIC_COOKIE) ? PH_CODE : PH_IDLE;
      end
      PH_CODE: begin
        if (b == OPT_END) begin
          phase = PH_IDLE;
        end else if (b != OPT_PAD) begin
          opt_code = b;
          phase    = PH_LEN;
        end
      end
      PH_LEN: begin
        remaining = b;
        pidx      = '0;
        phase     = (b == 0) ? PH_CODE : PH_DATA;
      end
      PH_DATA: begin
        outs.push_back('{KIND_OPTION, opt_code, pidx, 48'(b), ST_OK, 1'b0});
        if (opt_code == OPT_MSG_TYPE && !type_seen && pidx == 0) msg_type = b;
        pidx++;
        remaining--;
        if (remaining == 0) begin
          if (opt_code == OPT_MSG_TYPE) type_seen = 1'b1;
          phase = PH_CODE;
        end
      end
      default: ;
    endcase
    if (pos < 8'd240) pos++;
    if (last) begin
      val = '0;
      if (at < 8'd235) begin
        st = ST_SHORT;
      end else if (err != ST_OK) begin
        st = err;
      end else if (type_seen) begin
        st  = ST_OK;
        val = 48'(msg_type);
      end else begin
        st = ST_NO_TYPE;
      end
      outs.push_back('{KIND_STATUS, 8'd0, 8'd0, val, st, 1'b0});
      reset_parser();
    end
    if (outs.size() != 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[k]) parse_results_due.push_back(outs[k]);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    tx_bytes.push_back('{b, 1'b0, hold_next});
    hold_next = 1'b0;
  endtask

  task automatic close_packet();
    tx_bytes[tx_bytes.size() - 1].last = 1'b1;
    packets_built++;
  endtask

  task automatic add_header(input logic [7:0] op, input logic [7:0] htype,
                            input logic [7:0] hlen, input fill_e fill, input int nbytes);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      if (i == 0) b = op;
      if (i == 1) b = htype;
      if (i == 2) b = hlen;
      add_byte(b);
    end
  endtask

  task automatic add_cookie(input logic good);
    int         bad_at;
    logic [7:0] b;
    bad_at = good ? -1 : $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      b = 8'(MAGIC_COOKIE >> (24 - 8 * i));
      if (i == bad_at) b = b ^ 8'(1 << $urandom_range(0, 7));
      add_byte(b);
    end
  endtask

  task automatic add_option(input logic [7:0] code, input logic [7:0] len, input int nsent);
    add_byte(code);
    add_byte(len);
    repeat (nsent) add_byte(8'($urandom));
  endtask

  function automatic pace_e current_pace();
    return pace_e'((bytes_accepted / 120) % 4);
  endfunction

  function automatic logic sender_idle();
    case (current_pace())
      PACE_SEND_GAPS: return $urandom_range(0, 99) < 78;
      PACE_BOTH:      return $urandom_range(0, 99) < 29;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (current_pace())
      PACE_RECV_STALLS: return $urandom_range(0, 99) < 78;
      PACE_BOTH:        return $urandom_range(0, 99) < 29;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : byte_driver
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        parse_dhcp_byte(in_if.data_byte, in_if.last_byte);
        bytes_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_bytes.size() != 0 && !sender_idle() &&
            !(tx_bytes[0].hold && parse_results_due.size() != 0)) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= tx_bytes[0].data;
          in_if.last_byte <= tx_bytes[0].last;
          void'(tx_bytes.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    parse_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (parse_results_due.size() == 0) begin
          $error("unexpected result: kind %0d tag %0d value 0x%0h status %0d",
                 out_if.kind, out_if.tag, out_if.value, out_if.status);
          mismatches++;
        end else begin
          want = parse_results_due.pop_front();
          check_field("kind", 48'(want.kind), 48'(out_if.kind));
          check_field("tag", 48'(want.tag), 48'(out_if.tag));
          check_field("byte_index", 48'(want.idx), 48'(out_if.byte_index));
          check_field("value", want.value, out_if.value);
          check_field("status", 48'(want.status), 48'(out_if.status));
          check_field("last_result", 48'(want.last), 48'(out_if.last_result));
          results_checked++;
          if (want.kind == KIND_OPTION) option_results++;
          if (want.kind == KIND_STATUS) status_results++;
        end
      end
      out_if.ready <= !receiver_stall();
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    hold_next       = 1'b0;
    packets_built   = 0;
    bytes_accepted  = 0;
    results_checked = 0;
    option_results  = 0;
    status_results  = 0;
    mismatches      = 0;
    reset_parser();

    hold_next = 1'b1;
    add_byte(8'hFF);
    close_packet();
    add_header(8'd0, 8'd0, 8'd0, FILL_ZERO, 6);
    close_packet();
    repeat (2) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      close_packet();
    end

    hold_next = 1'b1;
    add_header(OP_REPLY, HTYPE_ETHER, HLEN_ETHER, FILL_ONES, 236);
    add_cookie(1'b1);
    add_byte(OPT_PAD);
    add_option(OPT_MSG_TYPE, 8'd0, 0);
    add_byte(OPT_MSG_TYPE);
    add_byte(8'd2);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(OPT_MSG_TYPE);
    add_byte(8'd1);
    add_byte(8'd7);
    add_option(8'd254, 8'd6, 6);
    add_option(8'd1, 8'd4, 4);
    add_option(OPT_MSG_TYPE, 8'd3, 2);
    close_packet();

    hold_next = 1'b1;
    add_header(OP_REQUEST, HTYPE_ETHER, HLEN_ETHER, FILL_RANDOM, 236);
    close_packet();

    total_bytes = tx_bytes.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted != total_bytes || parse_results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("summary: %0d bytes in %0d packets, %0d results checked", total_bytes,
             packets_built, results_checked);
    $display("summary: %0d option payload bytes, %0d end-of-packet reports", option_results,
             status_results);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
